// ===== rtl/core/tjc_pkg.sv =====
// track join cost: shared constants, configuration register codes and pipeline types
// no dependencies; imported by tjc_fexp and the top level (tjc_div does not use it)
`default_nettype none

package tjc_pkg;

  localparam int INDEX_BITS_DEF = 12;

  // quotient bits produced by the long dividers
  localparam int QUOT_BITS = 32;

  // magnitude of the approximate exponential, q.15
  localparam int VAL_BITS = 15;

  localparam logic [15:0] RADIUS_RST   = 16'd0;
  localparam logic [15:0] MAX_GAP_RST  = 16'd1;
  localparam logic [15:0] MEAN_MOVE_RST = 16'd0;

  // fast exponential constants
  localparam logic [20:0] SCH_SCALE  = 21'd1512775;
  localparam logic [31:0] SCH_BIAS   = 32'd1072632447;
  localparam logic [31:0] SCH_ONE    = 32'd1023 << 20;
  localparam logic [25:0] SCH_OFFSET = 26'(SCH_ONE - SCH_BIAS);

  typedef enum logic [1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_MAX_GAP   = 2'd1,
    CFG_MEAN_MOVE = 2'd2
  } tjc_cfg_idx_t;

  // control that travels alongside the dividers
  typedef struct packed {
    logic valid;
    logic linked;
    logic column_last;
    logic j_ge;
    logic j_sat;
    logic a_ge;
    logic a_sat;
  } tjc_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/tjc_div.sv =====
// track join cost: pipelined restoring divider, one quotient bit per stage
// no package dependency; caller guarantees the quotient fits in QW bits
`default_nettype none

module tjc_div #(
  parameter int DW = 50,
  parameter int VW = 32,
  parameter int QW = 32
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [QW-1:0] quotient
);

  logic [VW-1:0] rem_r [QW];
  logic [QW-1:0] wrd_r [QW];
  logic [VW-1:0] dvs_r [QW];

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_stage
      logic [VW-1:0] rem_in;
      logic [VW-1:0] dvs_in;
      logic [QW-1:0] wrd_in;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic          take;
      logic [VW-1:0] rem_nxt;
      logic [QW-1:0] wrd_nxt;

      if (s == 0) begin : g_first
        assign rem_in = VW'(dividend[DW-1:QW]);
        assign wrd_in = dividend[QW-1:0];
        assign dvs_in = divisor;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign wrd_in = wrd_r[s-1];
        assign dvs_in = dvs_r[s-1];
      end

      // low dividend bits shift out at the top, quotient bits shift in below
      assign trial   = {rem_in, wrd_in[QW-1]};
      assign take    = trial >= {1'b0, dvs_in};
      assign diff    = trial - {1'b0, dvs_in};
      assign rem_nxt = take ? diff[VW-1:0] : trial[VW-1:0];
      assign wrd_nxt = {wrd_in[QW-2:0], take};

      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        wrd_r[s] <= wrd_nxt;
        dvs_r[s] <= dvs_in;
      end
    end
  endgenerate

  assign quotient = wrd_r[QW-1];

endmodule

`default_nettype wire

// ===== rtl/core/tjc_fexp.sv =====
// track join cost: fast exp(-d*w) magnitude, two register stages plus output logic
// depends on tjc_pkg for the exponential constants
`default_nettype none

module tjc_fexp (
  input  wire logic                         clk,
  input  wire logic [31:0]                  d,
  input  wire logic [31:0]                  w,
  output logic      [tjc_pkg::VAL_BITS-1:0] value
);

  import tjc_pkg::*;

  logic [63:0] p_r;
  logic [63:0] p_nxt;
  logic [25:0] m_r;
  logic [25:0] m_nxt;
  logic        uf_r;
  logic        uf_nxt;
  logic [57:0] scaled;
  logic [26:0] n;
  logic [26:0] n_up;
  logic [6:0]  k;
  logic [26:0] k_full;
  logic [19:0] frac;
  logic [6:0]  sh;
  logic [20:0] mant;

  assign p_nxt  = 64'(d) * 64'(w);

  // exponent argument beyond sixteen underflows
  assign uf_nxt = |p_r[63:36];
  assign scaled = 58'(SCH_SCALE) * 58'(p_r[35:0]) + 58'h0_FFFF_FFFF;
  assign m_nxt  = scaled[57:32];

  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    m_r  <= m_nxt;
    uf_r <= uf_nxt;
  end

  assign n      = 27'(m_r) + 27'(SCH_OFFSET);
  assign n_up   = n + 27'h00F_FFFF;
  assign k      = n_up[26:20];
  assign k_full = {k, 20'd0};
  assign frac   = 20'(k_full - n);
  assign sh     = 7'd5 + k;
  assign mant   = {1'b1, frac} >> sh[4:0];

  always_comb begin
    if (uf_r || (sh >= 7'd21)) begin
      value = '0;
    end else begin
      value = mant[VAL_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/track_join_cost_top.sv =====
// track join cost: top level, input registers, gates, weight set-up and output register
// depends on tjc_pkg, tjc_div and tjc_fexp
`default_nettype none

// usage
//  - one candidate pair (track end, track start) per transaction on the in_ ports,
//    taken at a clock edge with start high and busy low; busy stays low, so a pair
//    can be offered on every cycle
//  - each pair yields exactly one result transaction, shown for one cycle with
//    out_valid high; the receiver cannot hold results off and none is needed
//  - throughput is one pair per cycle; the path from the accepting edge to the edge
//    that registers the result runs through three set-up stages (the first loaded
//    at the accepting edge), the three 32-stage dividers (distance over dt squared
//    and the two signal ratios), two weight stages, two stages of the fast
//    exponential and the output register
//  - cfg_ writes are taken on any cycle (cfg_ready is always high) but must only be
//    issued while no pair is in flight; index 3 is ignored
//  - synchronous reset clears every valid bit in the pipeline and restores the
//    register defaults: radius 0, maximum gap 1, mean move 0
//  - unlinked pairs report join cost 0; the alternative cost is always produced

module track_join_cost_top #(
  parameter int INDEX_BITS = tjc_pkg::INDEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pair input
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [INDEX_BITS-1:0] in_end_index,
  input  wire logic [23:0]           in_x_end,
  input  wire logic [23:0]           in_y_end,
  input  wire logic [15:0]           in_t_end,
  input  wire logic [31:0]           in_end_signal,
  input  wire logic [23:0]           in_x_start,
  input  wire logic [23:0]           in_y_start,
  input  wire logic [15:0]           in_t_start,
  input  wire logic [31:0]           in_start_signal,
  input  wire logic [31:0]           in_prior_signal,
  input  wire logic                  in_column_end,
  // result
  output logic                       out_valid,
  output logic      [INDEX_BITS-1:0] out_row_index,
  output logic                       out_linked,
  output logic      [15:0]           out_join_cost,
  output logic      [15:0]           out_alt_cost,
  output logic                       out_column_last,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  import tjc_pkg::*;

  localparam int SIDE_LEN = QUOT_BITS + 4;

  typedef struct packed {
    logic        ge;
    logic        sat;
    logic [48:0] dvd;
    logic [32:0] dvs;
  } wprep_t;

  // weight set-up: pick which way round the ratio is divided and flag saturation
  function automatic wprep_t weight_prep(input logic [31:0] num, input logic [32:0] den);
    wprep_t res;
    logic   zero;
    zero    = (den == 33'd0) || (num == 32'd0);
    res.ge  = {1'b0, num} >= den;
    if (res.ge) begin
      res.sat = zero || ({17'd0, num[31:16]} >= den);
      res.dvd = {1'b0, num, 16'd0};
      res.dvs = den;
    end else begin
      res.sat = zero || (41'(den) >= {1'b0, num, 8'd0});
      res.dvd = {den, 16'd0};
      res.dvs = {1'b0, num};
    end
    return res;
  endfunction

  // configuration registers and their squares
  logic [15:0] radius_r;
  logic [15:0] max_gap_r;
  logic [15:0] move_r;
  logic [31:0] r2_r;
  logic [31:0] move2_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      max_gap_r <= MAX_GAP_RST;
      move_r    <= MEAN_MOVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIUS:    radius_r  <= cfg_data;
        CFG_MAX_GAP:   max_gap_r <= cfg_data;
        CFG_MEAN_MOVE: move_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // squares follow the registers in the next cycle, long before a pair can reach them
  always_ff @(posedge clk) begin
    r2_r    <= 32'(radius_r) * 32'(radius_r);
    move2_r <= 32'(move_r) * 32'(move_r);
  end

  // stage a: differences and the joined signal
  logic                  a_valid_r;
  logic [INDEX_BITS-1:0] a_row_r;
  logic                  a_col_r;
  logic [24:0]           a_dx_r;
  logic [24:0]           a_dy_r;
  logic                  a_tpos_r;
  logic [15:0]           a_dt_r;
  logic [31:0]           a_s2_r;
  logic [31:0]           a_sp_r;
  logic [32:0]           a_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_row_r  <= in_end_index;
    a_col_r  <= in_column_end;
    a_dx_r   <= {in_x_start[23], in_x_start} - {in_x_end[23], in_x_end};
    a_dy_r   <= {in_y_start[23], in_y_start} - {in_y_end[23], in_y_end};
    a_tpos_r <= in_t_start > in_t_end;
    a_dt_r   <= in_t_start - in_t_end;
    a_s2_r   <= in_start_signal;
    a_sp_r   <= in_prior_signal;
    a_den_r  <= 33'(in_end_signal) + 33'(in_prior_signal);
  end

  // stage b: squares, time gate and divider operand selection
  logic [24:0] a_dx_mag;
  logic [24:0] a_dy_mag;
  wprep_t      a_jw;
  wprep_t      a_aw;

  assign a_dx_mag = a_dx_r[24] ? (25'd0 - a_dx_r) : a_dx_r;
  assign a_dy_mag = a_dy_r[24] ? (25'd0 - a_dy_r) : a_dy_r;
  assign a_jw     = weight_prep(a_s2_r, a_den_r);
  assign a_aw     = weight_prep(a_s2_r, {1'b0, a_sp_r});

  logic                  b_valid_r;
  logic [INDEX_BITS-1:0] b_row_r;
  logic                  b_col_r;
  logic [49:0]           b_dx2_r;
  logic [49:0]           b_dy2_r;
  logic [31:0]           b_dt2_r;
  logic                  b_gate_r;
  wprep_t                b_jw_r;
  wprep_t                b_aw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_row_r  <= a_row_r;
    b_col_r  <= a_col_r;
    b_dx2_r  <= 50'(a_dx_mag) * 50'(a_dx_mag);
    b_dy2_r  <= 50'(a_dy_mag) * 50'(a_dy_mag);
    b_dt2_r  <= 32'(a_dt_r) * 32'(a_dt_r);
    b_gate_r <= a_tpos_r && (a_dt_r <= max_gap_r);
    b_jw_r   <= a_jw;
    b_aw_r   <= a_aw;
  end

  // stage c: squared distance and the radius limit scaled by dt squared
  logic                  c_valid_r;
  logic [INDEX_BITS-1:0] c_row_r;
  logic                  c_col_r;
  logic [49:0]           c_s_r;
  logic [63:0]           c_lim_r;
  logic [31:0]           c_dt2_r;
  logic                  c_gate_r;
  wprep_t                c_jw_r;
  wprep_t                c_aw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_row_r  <= b_row_r;
    c_col_r  <= b_col_r;
    c_s_r    <= b_dx2_r + b_dy2_r;
    c_lim_r  <= 64'(r2_r) * 64'(b_dt2_r);
    c_dt2_r  <= b_dt2_r;
    c_gate_r <= b_gate_r;
    c_jw_r   <= b_jw_r;
    c_aw_r   <= b_aw_r;
  end

  // dividers: the distance quotient is only used when linked, where it fits 32 bits
  logic [QUOT_BITS-1:0] q_dist;
  logic [QUOT_BITS-1:0] q_join;
  logic [QUOT_BITS-1:0] q_alt;

  tjc_div #(.DW(50), .VW(32), .QW(QUOT_BITS)) u_div_dist (
    .clk      (clk),
    .dividend (c_s_r),
    .divisor  (c_dt2_r),
    .quotient (q_dist)
  );

  tjc_div #(.DW(49), .VW(33), .QW(QUOT_BITS)) u_div_join (
    .clk      (clk),
    .dividend (c_jw_r.dvd),
    .divisor  (c_jw_r.dvs),
    .quotient (q_join)
  );

  tjc_div #(.DW(49), .VW(33), .QW(QUOT_BITS)) u_div_alt (
    .clk      (clk),
    .dividend (c_aw_r.dvd),
    .divisor  (c_aw_r.dvs),
    .quotient (q_alt)
  );

  // side line: valid bit, gate result and weight flags ride beside the dividers
  tjc_side_t             side_nxt;
  tjc_side_t             side_r [SIDE_LEN];
  logic [INDEX_BITS-1:0] row_r  [SIDE_LEN];

  always_comb begin
    side_nxt.valid       = c_valid_r;
    side_nxt.linked      = c_gate_r && (64'(c_s_r) < c_lim_r);
    side_nxt.column_last = c_col_r;
    side_nxt.j_ge        = c_jw_r.ge;
    side_nxt.j_sat       = c_jw_r.sat;
    side_nxt.a_ge        = c_aw_r.ge;
    side_nxt.a_sat       = c_aw_r.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_LEN; i++) begin
        side_r[i] <= '0;
      end
    end else begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r[0] <= c_row_r;
    for (int i = 1; i < SIDE_LEN; i++) begin
      row_r[i] <= row_r[i-1];
    end
  end

  // weight stage 1: square the reciprocal ratio for the small-ratio case
  logic [31:0] w1_qj_r;
  logic [31:0] w1_qa_r;
  logic [47:0] w1_sqj_r;
  logic [47:0] w1_sqa_r;
  logic [31:0] w1_dist_r;

  always_ff @(posedge clk) begin
    w1_qj_r   <= q_join;
    w1_qa_r   <= q_alt;
    w1_sqj_r  <= 48'(q_join[23:0]) * 48'(q_join[23:0]);
    w1_sqa_r  <= 48'(q_alt[23:0]) * 48'(q_alt[23:0]);
    w1_dist_r <= q_dist;
  end

  // weight stage 2: final q16.16 weights with saturation
  logic [31:0] w2_wj_r;
  logic [31:0] w2_wa_r;
  logic [31:0] w2_dist_r;

  always_ff @(posedge clk) begin
    if (side_r[QUOT_BITS].j_sat) begin
      w2_wj_r <= '1;
    end else if (side_r[QUOT_BITS].j_ge) begin
      w2_wj_r <= w1_qj_r;
    end else begin
      w2_wj_r <= w1_sqj_r[47:16];
    end
    if (side_r[QUOT_BITS].a_sat) begin
      w2_wa_r <= '1;
    end else if (side_r[QUOT_BITS].a_ge) begin
      w2_wa_r <= w1_qa_r;
    end else begin
      w2_wa_r <= w1_sqa_r[47:16];
    end
    w2_dist_r <= w1_dist_r;
  end

  // fast exponentials, two stages each
  logic [VAL_BITS-1:0] val_join;
  logic [VAL_BITS-1:0] val_alt;

  tjc_fexp u_fexp_join (
    .clk   (clk),
    .d     (w2_dist_r),
    .w     (w2_wj_r),
    .value (val_join)
  );

  tjc_fexp u_fexp_alt (
    .clk   (clk),
    .d     (move2_r),
    .w     (w2_wa_r),
    .value (val_alt)
  );

  // output register
  tjc_side_t             side_end;
  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_row_r;
  logic                  out_linked_r;
  logic [15:0]           out_join_r;
  logic [15:0]           out_alt_r;
  logic                  out_col_r;

  assign side_end = side_r[SIDE_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r    <= row_r[SIDE_LEN-1];
    out_linked_r <= side_end.linked;
    out_join_r   <= side_end.linked ? (16'd0 - 16'(val_join)) : 16'd0;
    out_alt_r    <= 16'd0 - 16'(val_alt);
    out_col_r    <= side_end.column_last;
  end

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_r;
  assign out_linked      = out_linked_r;
  assign out_join_cost   = out_join_r;
  assign out_alt_cost    = out_alt_r;
  assign out_column_last = out_col_r;

  // an unlinked pair never carries a join cost
  a_unlinked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_linked |-> out_join_cost == 16'd0)
    else $error("unlinked pair with non-zero join cost");

  // costs are never positive
  a_join_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_join_cost[15] || (out_join_cost == 16'd0))
    else $error("positive join cost");

  a_alt_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alt_cost[15] || (out_alt_cost == 16'd0))
    else $error("positive alternative cost");

  // a linked pair entering the side line passed the time gate
  a_link_gate: assert property (@(posedge clk) disable iff (!rst_n)
    side_r[0].valid && side_r[0].linked |-> $past(c_gate_r))
    else $error("link without time gate");

endmodule

`default_nettype wire
